// ----- rtl/core/pba_pkg.sv -----
// Package for the pooled block allocator: sizes, codes, state encoding and
// the structs passed between the allocator modules. No dependencies.
package pba_pkg;

   localparam int BLOCKS_PER_POOL = 16;
   localparam int MAX_POOLS       = 8;

   // Widths of the request and response fields.
   localparam int POOL_W = 3;
   localparam int SLOT_W = 4;
   localparam int ERR_W  = 2;

   // Pool list index and pool count widths.
   localparam int IDX_W = $clog2(MAX_POOLS);
   localparam int CNT_W = $clog2(MAX_POOLS + 1);

   // The shared lowest-zero finder covers a bitmap or the active pool mask.
   localparam int FIND_W     = (BLOCKS_PER_POOL > MAX_POOLS) ? BLOCKS_PER_POOL : MAX_POOLS;
   localparam int FIND_IDX_W = $clog2(FIND_W);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 2'd0,
      ERR_NO_POOL  = 2'd1,
      ERR_INACTIVE = 2'd2,
      ERR_DOUBLE   = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_OPEN,
      ST_CHECK,
      ST_SEARCH,
      ST_SHIFT,
      ST_POST
   } state_type;

   typedef struct packed {
      logic              cmd;
      logic [POOL_W-1:0] free_pool;
      logic [SLOT_W-1:0] free_slot;
   } req_data_type;

   typedef struct packed {
      logic              ok;
      logic [POOL_W-1:0] pool_id;
      logic [SLOT_W-1:0] slot_id;
      logic [ERR_W-1:0]  error_code;
      logic              pool_opened;
      logic              pool_closed;
   } rsp_data_type;

   typedef struct packed {
      logic         valid;
      rsp_data_type data;
   } res_type;

endpackage

// ----- rtl/core/pba_if.sv -----
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on pba_pkg for the field widths.
interface pba_req_if;
   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic [pba_pkg::POOL_W-1:0] free_pool;
   logic [pba_pkg::SLOT_W-1:0] free_slot;

   modport source (output valid, output cmd, output free_pool, output free_slot,
                   input ready);
   modport sink   (input valid, input cmd, input free_pool, input free_slot,
                   output ready);
endinterface

interface pba_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       ok;
   logic [pba_pkg::POOL_W-1:0] pool_id;
   logic [pba_pkg::SLOT_W-1:0] slot_id;
   logic [pba_pkg::ERR_W-1:0]  error_code;
   logic                       pool_opened;
   logic                       pool_closed;

   modport source (output valid, output ok, output pool_id, output slot_id,
                   output error_code, output pool_opened, output pool_closed,
                   input ready);
   modport sink   (input valid, input ok, input pool_id, input slot_id,
                   input error_code, input pool_opened, input pool_closed,
                   output ready);
endinterface

// ----- rtl/core/pba_find.sv -----
// Shared lowest-zero finder, used on pool bitmaps and on the active pool mask.
// Depends on pba_pkg for its width.
module pba_find (
   input  logic [pba_pkg::FIND_W-1:0]     vec,
   output logic                           found,
   output logic [pba_pkg::FIND_IDX_W-1:0] index
);

   always_comb begin
      found = 1'b0;
      index = '0;
      // Scan from the top so that the lowest clear bit is the last to win.
      for (int i = pba_pkg::FIND_W - 1; i >= 0; i--) begin
         if (!vec[i]) begin
            found = 1'b1;
            index = pba_pkg::FIND_IDX_W'(i);
         end
      end
   end

endmodule

// ----- rtl/core/pba_ctrl.sv -----
// Allocator state (bitmaps, active mask, pool order list) and the sequencer
// that walks it. Depends on pba_pkg and pba_find.
module pba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  pba_pkg::req_data_type req_data,
   output logic                  req_ready,
   output pba_pkg::res_type      res,
   input  logic                  res_take
);

   pba_pkg::state_type state_ff, state_in;

   logic [pba_pkg::BLOCKS_PER_POOL-1:0] map_ff   [pba_pkg::MAX_POOLS];
   logic [pba_pkg::BLOCKS_PER_POOL-1:0] map_in;
   logic [pba_pkg::POOL_W-1:0]          order_ff [pba_pkg::MAX_POOLS];
   logic [pba_pkg::POOL_W-1:0]          order_in;
   logic                                map_we, order_we;
   logic [pba_pkg::IDX_W-1:0]           order_wr_idx;

   logic [pba_pkg::MAX_POOLS-1:0] active_ff, active_in;
   logic [pba_pkg::CNT_W-1:0]     length_ff, length_in;
   logic [pba_pkg::CNT_W-1:0]     idx_ff, idx_in;
   logic [pba_pkg::CNT_W-1:0]     idx_next;
   pba_pkg::req_data_type         cmd_ff, cmd_in;
   pba_pkg::rsp_data_type         res_ff, res_in;

   logic [pba_pkg::IDX_W-1:0]           rd_idx;
   logic [pba_pkg::POOL_W-1:0]          ord_rd;
   logic [pba_pkg::POOL_W-1:0]          map_idx;
   logic [pba_pkg::BLOCKS_PER_POOL-1:0] map_rd;
   logic [pba_pkg::BLOCKS_PER_POOL-1:0] map_clr;
   logic [pba_pkg::FIND_W-1:0]          find_vec;
   logic                                find_ok;
   logic [pba_pkg::FIND_IDX_W-1:0]      find_idx;
   logic                                slot_used;

   pba_find u_find (
      .vec   (find_vec),
      .found (find_ok),
      .index (find_idx)
   );

   assign idx_next = idx_ff + 1'b1;

   // One read of the order list per cycle; the shift step reads one ahead.
   assign rd_idx = (state_ff == pba_pkg::ST_SHIFT) ? idx_next[pba_pkg::IDX_W-1:0]
                                                   : idx_ff[pba_pkg::IDX_W-1:0];
   assign ord_rd = order_ff[rd_idx];

   always_comb begin
      unique case (state_ff)
         pba_pkg::ST_WALK: map_idx = ord_rd;
         pba_pkg::ST_OPEN: map_idx = find_idx[pba_pkg::POOL_W-1:0];
         default:          map_idx = cmd_ff.free_pool;
      endcase
   end

   assign map_rd    = map_ff[map_idx];
   assign slot_used = map_rd[cmd_ff.free_slot];

   always_comb begin
      map_clr                    = map_rd;
      map_clr[cmd_ff.free_slot]  = 1'b0;
   end

   // The finder sees either the current pool's bitmap or the active mask;
   // bits beyond the real width read as taken.
   always_comb begin
      for (int i = 0; i < pba_pkg::FIND_W; i++) begin
         if (state_ff == pba_pkg::ST_OPEN) begin
            find_vec[i] = (i < pba_pkg::MAX_POOLS) ? active_ff[i] : 1'b1;
         end else begin
            find_vec[i] = (i < pba_pkg::BLOCKS_PER_POOL) ? map_rd[i] : 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pba_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_data.cmd == pba_pkg::CMD_FREE) begin
                  state_in = pba_pkg::ST_CHECK;
               end else if (length_ff == '0) begin
                  state_in = pba_pkg::ST_OPEN;
               end else begin
                  state_in = pba_pkg::ST_WALK;
               end
            end
         end
         pba_pkg::ST_WALK: begin
            if (find_ok) begin
               state_in = pba_pkg::ST_POST;
            end else if (idx_next == length_ff) begin
               state_in = pba_pkg::ST_OPEN;
            end
         end
         pba_pkg::ST_OPEN: state_in = pba_pkg::ST_POST;
         pba_pkg::ST_CHECK: begin
            if (active_ff[cmd_ff.free_pool] && slot_used && map_clr == '0) begin
               state_in = pba_pkg::ST_SEARCH;
            end else begin
               state_in = pba_pkg::ST_POST;
            end
         end
         pba_pkg::ST_SEARCH: begin
            if (ord_rd == cmd_ff.free_pool) begin
               state_in = pba_pkg::ST_SHIFT;
            end
         end
         pba_pkg::ST_SHIFT: begin
            if (idx_next >= length_ff) begin
               state_in = pba_pkg::ST_POST;
            end
         end
         pba_pkg::ST_POST: begin
            if (res_take) begin
               state_in = pba_pkg::ST_IDLE;
            end
         end
         default: state_in = pba_pkg::ST_IDLE;
      endcase
   end

   // Datapath and state updates.
   always_comb begin
      cmd_in       = cmd_ff;
      res_in       = res_ff;
      idx_in       = idx_ff;
      active_in    = active_ff;
      length_in    = length_ff;
      map_we       = 1'b0;
      map_in       = map_rd;
      order_we     = 1'b0;
      order_wr_idx = rd_idx;
      order_in     = ord_rd;
      unique case (state_ff)
         pba_pkg::ST_IDLE: begin
            cmd_in = req_data;
            idx_in = '0;
         end
         pba_pkg::ST_WALK: begin
            if (find_ok) begin
               map_we                 = 1'b1;
               map_in[find_idx[pba_pkg::SLOT_W-1:0]] = 1'b1;
               res_in.ok              = 1'b1;
               res_in.pool_id         = ord_rd;
               res_in.slot_id         = find_idx[pba_pkg::SLOT_W-1:0];
               res_in.error_code      = pba_pkg::ERR_NONE;
               res_in.pool_opened     = 1'b0;
               res_in.pool_closed     = 1'b0;
            end else begin
               idx_in = idx_next;
            end
         end
         pba_pkg::ST_OPEN: begin
            res_in.slot_id     = '0;
            res_in.pool_closed = 1'b0;
            if (find_ok) begin
               map_we                = 1'b1;
               map_in                = pba_pkg::BLOCKS_PER_POOL'(1);
               active_in[map_idx]    = 1'b1;
               order_we              = 1'b1;
               order_wr_idx          = length_ff[pba_pkg::IDX_W-1:0];
               order_in              = map_idx;
               length_in             = length_ff + 1'b1;
               res_in.ok             = 1'b1;
               res_in.pool_id        = map_idx;
               res_in.error_code     = pba_pkg::ERR_NONE;
               res_in.pool_opened    = 1'b1;
            end else begin
               res_in.ok          = 1'b0;
               res_in.pool_id     = '0;
               res_in.error_code  = pba_pkg::ERR_NO_POOL;
               res_in.pool_opened = 1'b0;
            end
         end
         pba_pkg::ST_CHECK: begin
            res_in.pool_id     = cmd_ff.free_pool;
            res_in.slot_id     = cmd_ff.free_slot;
            res_in.pool_opened = 1'b0;
            res_in.pool_closed = 1'b0;
            if (!active_ff[cmd_ff.free_pool]) begin
               res_in.ok         = 1'b0;
               res_in.error_code = pba_pkg::ERR_INACTIVE;
            end else if (!slot_used) begin
               res_in.ok         = 1'b0;
               res_in.error_code = pba_pkg::ERR_DOUBLE;
            end else begin
               map_we            = 1'b1;
               map_in            = map_clr;
               res_in.ok         = 1'b1;
               res_in.error_code = pba_pkg::ERR_NONE;
               if (map_clr == '0) begin
                  active_in[cmd_ff.free_pool] = 1'b0;
                  res_in.pool_closed          = 1'b1;
               end
            end
         end
         pba_pkg::ST_SEARCH: begin
            if (ord_rd != cmd_ff.free_pool) begin
               idx_in = idx_next;
            end
         end
         pba_pkg::ST_SHIFT: begin
            // Close the gap one entry per cycle, then drop the tail.
            if (idx_next < length_ff) begin
               order_we     = 1'b1;
               order_wr_idx = idx_ff[pba_pkg::IDX_W-1:0];
               order_in     = ord_rd;
               idx_in       = idx_next;
            end else begin
               length_in = length_ff - 1'b1;
            end
         end
         pba_pkg::ST_POST: begin
         end
         default: begin
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready = (state_ff == pba_pkg::ST_IDLE);
      res.valid = (state_ff == pba_pkg::ST_POST);
      res.data  = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pba_pkg::ST_IDLE;
         active_ff <= '0;
         length_ff <= '0;
         idx_ff    <= '0;
         for (int i = 0; i < pba_pkg::MAX_POOLS; i++) begin
            map_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         length_ff <= length_in;
         idx_ff    <= idx_in;
         if (map_we) begin
            map_ff[map_idx] <= map_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      res_ff <= res_in;
      if (order_we) begin
         order_ff[order_wr_idx] <= order_in;
      end
   end

`ifndef SYNTHESIS
   a_length_range: assert property (@(posedge clock) disable iff (reset)
      length_ff <= pba_pkg::CNT_W'(pba_pkg::MAX_POOLS))
      else $error("pool list longer than the number of pools");

   a_length_matches_active: assert property (@(posedge clock) disable iff (reset)
      state_ff == pba_pkg::ST_IDLE |-> $countones(active_ff) == int'(length_ff))
      else $error("pool list length disagrees with the active mask");

   a_open_only_when_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pba_pkg::ST_OPEN && !find_ok) |-> active_ff == '1)
      else $error("out of pools reported with an inactive pool left");

   a_post_releases: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pba_pkg::ST_POST && res_take) |=> state_ff == pba_pkg::ST_IDLE)
      else $error("sequencer did not return to idle after handing off a result");

   a_opened_is_ok: assert property (@(posedge clock) disable iff (reset)
      res.valid && (res.data.pool_opened || res.data.pool_closed) |-> res.data.ok)
      else $error("pool opened or closed on a failed request");
`endif

endmodule

// ----- rtl/core/pooled_block_allocator.sv -----
// Pooled block allocator top level: request/response channels, the
// sequencer, and the response register. Depends on pba_pkg, pba_if, pba_ctrl.
//
// The allocator hands out and takes back fixed-size blocks named by a pool
// number and a slot. An allocate request looks at one active pool bitmap per
// cycle in list order until a pool with room is found; when all active pools
// are full, a new pool is opened or, if none is left, out of pools is reported.
// A free request checks and clears its slot; one that empties its pool then
// searches and compacts the pool list one entry per cycle.
// The request channel is not ready while a request is in progress. A finished
// response sits in an output register, so the next request is accepted while
// it waits. All bitmaps are cleared by reset directly; there is no clearing pass.
module pooled_block_allocator (
   input logic      clock,
   input logic      reset,
   pba_req_if.sink  req_bus,
   pba_rsp_if.source rsp_bus
);

   pba_pkg::req_data_type req_data;
   pba_pkg::res_type      res;
   logic                  res_take;
   logic                  rsp_valid_ff, rsp_valid_in;
   pba_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   assign req_data.cmd       = req_bus.cmd;
   assign req_data.free_pool = req_bus.free_pool;
   assign req_data.free_slot = req_bus.free_slot;

   pba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_data  (req_data),
      .req_ready (req_bus.ready),
      .res       (res),
      .res_take  (res_take)
   );

   // The output register takes a new result once the old one has gone.
   assign res_take = res.valid && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.data;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.ok          = rsp_data_ff.ok;
   assign rsp_bus.pool_id     = rsp_data_ff.pool_id;
   assign rsp_bus.slot_id     = rsp_data_ff.slot_id;
   assign rsp_bus.error_code  = rsp_data_ff.error_code;
   assign rsp_bus.pool_opened = rsp_data_ff.pool_opened;
   assign rsp_bus.pool_closed = rsp_data_ff.pool_closed;

endmodule

// ----- tb/pooled_block_allocator_tb.sv -----
// Testbench for the pooled block allocator: a scoreboard package that predicts
// every response, and the top module that drives requests and checks responses.
// Depends on pba_pkg, pba_if and the pooled_block_allocator RTL.
package pba_tb_pkg;
   import pba_pkg::*;

   class alloc_ledger;
      // Predicted allocator state.
      logic [BLOCKS_PER_POOL-1:0] slot_map [MAX_POOLS];
      logic [MAX_POOLS-1:0]       pool_live;
      logic [POOL_W-1:0]          pool_list [MAX_POOLS];
      int                         list_len;

      rsp_data_type pending_grants [$];
      int errors;
      int n_alloc, n_opened, n_no_pool, n_free, n_closed, n_rejected;

      function new();
         foreach (slot_map[p]) slot_map[p] = '0;
         foreach (pool_list[p]) pool_list[p] = '0;
         pool_live = '0;
         list_len  = 0;
         errors    = 0;
         n_alloc = 0; n_opened = 0; n_no_pool = 0;
         n_free = 0; n_closed = 0; n_rejected = 0;
      endfunction

      // Works out the response to an accepted request, updates the predicted
      // state and queues the response.
      function rsp_data_type note_request(req_data_type r);
         rsp_data_type g;
         logic [POOL_W-1:0] p;
         bit found;
         int i, s, j;
         g = '0;
         found = 0;
         if (r.cmd == CMD_ALLOC) begin
            n_alloc++;
            for (i = 0; i < list_len && !found; i++) begin
               p = pool_list[i];
               for (s = 0; s < BLOCKS_PER_POOL && !found; s++) begin
                  if (!slot_map[p][s]) begin
                     slot_map[p][s] = 1'b1;
                     g.ok      = 1'b1;
                     g.pool_id = p;
                     g.slot_id = SLOT_W'(s);
                     found     = 1;
                  end
               end
            end
            // Every listed pool is full, so open the lowest inactive one.
            for (i = 0; i < MAX_POOLS && !found; i++) begin
               if (!pool_live[i] && list_len < MAX_POOLS) begin
                  pool_live[i]        = 1'b1;
                  slot_map[i]         = '0;
                  slot_map[i][0]      = 1'b1;
                  pool_list[list_len] = POOL_W'(i);
                  list_len++;
                  g.ok          = 1'b1;
                  g.pool_id     = POOL_W'(i);
                  g.slot_id     = '0;
                  g.pool_opened = 1'b1;
                  found         = 1;
                  n_opened++;
               end
            end
            if (!found) begin
               g.error_code = ERR_NO_POOL;
               n_no_pool++;
            end
         end else begin
            n_free++;
            g.pool_id = r.free_pool;
            g.slot_id = r.free_slot;
            if (!pool_live[r.free_pool]) begin
               g.error_code = ERR_INACTIVE;
               n_rejected++;
            end else if (!slot_map[r.free_pool][r.free_slot]) begin
               g.error_code = ERR_DOUBLE;
               n_rejected++;
            end else begin
               slot_map[r.free_pool][r.free_slot] = 1'b0;
               g.ok = 1'b1;
               if (slot_map[r.free_pool] == '0) begin
                  // The pool emptied: close it and close the gap in the list.
                  pool_live[r.free_pool] = 1'b0;
                  for (i = 0; i < list_len && !found; i++) begin
                     if (pool_list[i] == r.free_pool) begin
                        for (j = i; j + 1 < list_len; j++) pool_list[j] = pool_list[j + 1];
                        list_len--;
                        found = 1;
                     end
                  end
                  g.pool_closed = 1'b1;
                  n_closed++;
               end
            end
         end
         pending_grants.push_back(g);
         return g;
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_data_type got);
         rsp_data_type want;
         if (pending_grants.size() == 0) begin
            $error("response arrived with no request outstanding");
            errors++;
            return;
         end
         want = pending_grants.pop_front();
         check_field("ok", want.ok, got.ok);
         check_field("pool_id", want.pool_id, got.pool_id);
         check_field("slot_id", want.slot_id, got.slot_id);
         check_field("error_code", want.error_code, got.error_code);
         check_field("pool_opened", want.pool_opened, got.pool_opened);
         check_field("pool_closed", want.pool_closed, got.pool_closed);
      endfunction
   endclass
endpackage

module pooled_block_allocator_tb;
   import pba_pkg::*;
   import pba_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 600;
   localparam int IDLE_LIMIT   = 3000;

   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind;

   typedef struct packed {
      logic [POOL_W-1:0] pool;
      logic [SLOT_W-1:0] slot;
   } block_handle_type;

   logic clock;
   logic reset;

   pba_req_if req_bus ();
   pba_rsp_if rsp_bus ();

   pooled_block_allocator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   alloc_ledger      ledger = new();
   block_handle_type live_blocks [$];
   bit               req_quiet;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Called at a clock edge; returns at the edge where the request is accepted.
   task automatic issue_request(input logic cmd, input logic [POOL_W-1:0] pool,
                                input logic [SLOT_W-1:0] slot);
      int gap;
      int i;
      req_data_type item;
      rsp_data_type grant;
      block_handle_type h;
      gap = req_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.free_pool <= pool;
      req_bus.free_slot <= slot;
      do @(posedge clock); while (!req_bus.ready);
      item.cmd       = cmd;
      item.free_pool = pool;
      item.free_slot = slot;
      grant = ledger.note_request(item);
      h.pool = grant.pool_id;
      h.slot = grant.slot_id;
      if (grant.ok && cmd == CMD_ALLOC) begin
         live_blocks.push_back(h);
      end else if (grant.ok) begin
         for (i = 0; i < live_blocks.size(); i++) begin
            if (live_blocks[i] == h) begin
               live_blocks.delete(i);
               break;
            end
         end
      end
   endtask

   // Response side: random stalls, with stretches of none at all.
   initial begin
      int stall;
      int span;
      bit quiet;
      stall = 0;
      span  = 0;
      quiet = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            quiet = ($urandom_range(0, 3) == 0);
            span  = $urandom_range(50, 400);
         end
         span--;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 35) stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      rsp_data_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.ok          = rsp_bus.ok;
         got.pool_id     = rsp_bus.pool_id;
         got.slot_id     = rsp_bus.slot_id;
         got.error_code  = rsp_bus.error_code;
         got.pool_opened = rsp_bus.pool_opened;
         got.pool_closed = rsp_bus.pool_closed;
         ledger.check_response(got);
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle = 0;
         else
            idle++;
      end
      $display("Watchdog: nothing moved on either channel for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int issued;
      int len;
      int alloc_pct;
      int idx;
      phase_kind kind;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_ALLOC;
      req_bus.free_pool = '0;
      req_bus.free_slot = '0;
      req_quiet         = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: frees of inactive pools, opening, double frees, closing.
      issue_request(CMD_FREE, 3'd0, 4'd0);
      issue_request(CMD_FREE, 3'd7, 4'd15);
      issue_request(CMD_ALLOC, 3'd7, 4'd15);
      issue_request(CMD_ALLOC, 3'd0, 4'd0);
      issue_request(CMD_FREE, 3'd0, 4'd5);
      issue_request(CMD_FREE, 3'd0, 4'd15);
      issue_request(CMD_FREE, 3'd0, 4'd1);
      issue_request(CMD_FREE, 3'd0, 4'd1);
      issue_request(CMD_FREE, 3'd1, 4'd0);
      issue_request(CMD_FREE, 3'd0, 4'd0);
      issue_request(CMD_FREE, 3'd0, 4'd0);
      issue_request(CMD_ALLOC, 3'd5, 4'd10);
      issue_request(CMD_FREE, 3'd0, 4'd0);

      // Random phases. The first one fills every pool to reach out of pools;
      // later ones alternate between filling, draining and a mix.
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         if (issued == 0) begin
            kind = PH_FILL;
            len  = 200;
         end else begin
            kind = phase_kind'($urandom_range(0, 2));
            len  = $urandom_range(40, 160);
         end
         if (len > RANDOM_ITEMS - issued) len = RANDOM_ITEMS - issued;
         case (kind)
            PH_FILL:  alloc_pct = 92;
            PH_DRAIN: alloc_pct = 12;
            default:  alloc_pct = 50;
         endcase
         req_quiet = ($urandom_range(0, 3) == 0);
         repeat (len) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
               issue_request(CMD_ALLOC, POOL_W'($urandom), SLOT_W'($urandom));
            end else if (live_blocks.size() != 0 && $urandom_range(0, 99) < 85) begin
               idx = $urandom_range(0, live_blocks.size() - 1);
               issue_request(CMD_FREE, live_blocks[idx].pool, live_blocks[idx].slot);
            end else begin
               issue_request(CMD_FREE, POOL_W'($urandom), SLOT_W'($urandom));
            end
            issued++;
         end
      end
      req_bus.valid <= 1'b0;

      while (ledger.pending_grants.size() != 0) @(posedge clock);
      repeat (2 * MAX_POOLS + 8) @(posedge clock);

      $display("Covered %0d allocations (%0d opened a pool, %0d out of pools)",
               ledger.n_alloc, ledger.n_opened, ledger.n_no_pool);
      $display("and %0d frees (%0d closed a pool, %0d rejected); %0d mismatches",
               ledger.n_free, ledger.n_closed, ledger.n_rejected, ledger.errors);
      if (ledger.errors == 0 && ledger.pending_grants.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
